// ----- sv/fdm_pkg.sv -----
// floppy drive mechanics: shared types, command codes and register indexes
// used by fdm_core and floppy_drive_mechanics
`default_nettype none

package fdm_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_MOTOR_ON  = 3'd1,
    CMD_MOTOR_OFF = 3'd2,
    CMD_SELECT    = 3'd3,
    CMD_UNSELECT  = 3'd4,
    CMD_STEP      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    REG_CYLINDER_COUNT = 2'd0,
    REG_MOTOR_START_MS = 2'd1,
    REG_HEAD_LOAD_MS   = 2'd2,
    REG_TRACK_STEP_MS  = 2'd3
  } reg_index_t;

  localparam logic [7:0]  CYLINDER_COUNT_RST = 8'd40;
  localparam logic [11:0] MOTOR_START_MS_RST = 12'd500;
  localparam logic [7:0]  HEAD_LOAD_MS_RST   = 8'd16;
  localparam logic [7:0]  TRACK_STEP_MS_RST  = 8'd8;

  localparam logic [11:0] SPIN_MAX = 12'hFFF;
  localparam logic [7:0]  LOAD_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0]  cylinder_count;
    logic [11:0] motor_start_ms;
    logic [7:0]  head_load_ms;
    logic [7:0]  track_step_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0] since_last_step_ms;
    logic       first_step;
    logic       step_up;
    logic [2:0] cmd;
  } item_t;

  typedef struct packed {
    logic       full_speed;
    logic       ready_res;
    logic [7:0] cylinder;
    logic       accepted;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/fdm_core.sv -----
// floppy drive mechanics: drive state registers and per-command update logic
// depends on fdm_pkg
`default_nettype none

module fdm_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire fdm_pkg::item_t  item,
  input  wire fdm_pkg::cfg_t   cfg,
  output fdm_pkg::result_t     result
);
  import fdm_pkg::*;

  logic        motor_stopped, motor_stopped_next;
  logic        drive_selected, drive_selected_next;
  logic        heads_unloaded, heads_unloaded_next;
  logic [11:0] spin_elapsed, spin_elapsed_next;
  logic [7:0]  load_elapsed, load_elapsed_next;
  logic [7:0]  head_cylinder, head_cylinder_next;

  logic       ok;
  logic       fs;
  logic       loaded;
  logic [8:0] cyl_plus;

  always_comb begin
    motor_stopped_next  = motor_stopped;
    drive_selected_next = drive_selected;
    heads_unloaded_next = heads_unloaded;
    spin_elapsed_next   = spin_elapsed;
    load_elapsed_next   = load_elapsed;
    head_cylinder_next  = head_cylinder;
    ok                  = 1'b1;
    cyl_plus            = {1'b0, head_cylinder} + 9'd1;
    unique case (item.cmd)
      CMD_TICK: begin
        if (spin_elapsed != SPIN_MAX) spin_elapsed_next = spin_elapsed + 12'd1;
        if (load_elapsed != LOAD_MAX) load_elapsed_next = load_elapsed + 8'd1;
      end
      CMD_MOTOR_ON: begin
        if (motor_stopped) spin_elapsed_next = '0;
        motor_stopped_next = 1'b0;
      end
      CMD_MOTOR_OFF: begin
        motor_stopped_next = 1'b1;
      end
      CMD_SELECT: begin
        if (!motor_stopped) begin
          drive_selected_next = 1'b1;
          if (heads_unloaded) begin
            load_elapsed_next   = '0;
            heads_unloaded_next = 1'b0;
          end
        end else begin
          ok = 1'b0;
        end
      end
      CMD_UNSELECT: begin
        drive_selected_next = 1'b0;
        heads_unloaded_next = 1'b1;
      end
      CMD_STEP: begin
        if (!item.first_step && (item.since_last_step_ms < cfg.track_step_ms)) begin
          ok = 1'b0;
        end else if (item.step_up) begin
          if (cyl_plus >= {1'b0, cfg.cylinder_count}) ok = 1'b0;
          else head_cylinder_next = cyl_plus[7:0];
        end else begin
          if (head_cylinder == 8'd0) ok = 1'b0;
          else head_cylinder_next = head_cylinder - 8'd1;
        end
      end
      default: begin
      end
    endcase

    fs     = !motor_stopped_next && (spin_elapsed_next >= cfg.motor_start_ms);
    loaded = !heads_unloaded_next && (load_elapsed_next >= cfg.head_load_ms);
    result.accepted   = ok;
    result.cylinder   = head_cylinder_next;
    result.ready_res  = drive_selected_next && loaded && fs;
    result.full_speed = fs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_stopped  <= 1'b1;
      drive_selected <= 1'b0;
      heads_unloaded <= 1'b1;
      spin_elapsed   <= '0;
      load_elapsed   <= '0;
      head_cylinder  <= '0;
    end else if (adv) begin
      motor_stopped  <= motor_stopped_next;
      drive_selected <= drive_selected_next;
      heads_unloaded <= heads_unloaded_next;
      spin_elapsed   <= spin_elapsed_next;
      load_elapsed   <= load_elapsed_next;
      head_cylinder  <= head_cylinder_next;
    end
  end

  a_ready_needs_speed: assert property (@(posedge clk) disable iff (rst)
    result.ready_res |-> result.full_speed)
    else $error("ready without full speed");

  a_head_only_on_step: assert property (@(posedge clk) disable iff (rst)
    !(adv && item.cmd == CMD_STEP) |=> $stable(head_cylinder))
    else $error("head moved without a step");

  a_step_moves_head: assert property (@(posedge clk) disable iff (rst)
    (adv && item.cmd == CMD_STEP && result.accepted) |=>
      (head_cylinder != $past(head_cylinder)))
    else $error("accepted step left head in place");

  a_motor_off: assert property (@(posedge clk) disable iff (rst)
    (adv && item.cmd == CMD_MOTOR_OFF) |=> motor_stopped)
    else $error("motor still running after motor off");

endmodule

`default_nettype wire

// ----- sv/floppy_drive_mechanics.sv -----
// floppy drive mechanics top level: stream ports, config registers,
// input register and result register around fdm_core; depends on fdm_pkg
// datapath: input register, then the fdm_core state update, then the result register
// throughput: one item per cycle while m_tready does not stall the result, set by the state update in fdm_core
// input side keeps taking items while a result waits, until both stages are full
// synchronous reset clears the pipeline, drive state and config to defaults
`default_nettype none

module floppy_drive_mechanics (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // cmd[2:0], step_up, first_step, since_last_step_ms
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // accepted, cylinder[7:0], ready_res, full_speed
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  import fdm_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    adv;
  result_t res_comb;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cylinder_count <= CYLINDER_COUNT_RST;
      cfg.motor_start_ms <= MOTOR_START_MS_RST;
      cfg.head_load_ms   <= HEAD_LOAD_MS_RST;
      cfg.track_step_ms  <= TRACK_STEP_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_CYLINDER_COUNT: cfg.cylinder_count <= cfg_data[7:0];
        REG_MOTOR_START_MS: cfg.motor_start_ms <= cfg_data;
        REG_HEAD_LOAD_MS:   cfg.head_load_ms   <= cfg_data[7:0];
        REG_TRACK_STEP_MS:  cfg.track_step_ms  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[12:0];
    end
  end

  fdm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .item   (in_item),
    .cfg    (cfg),
    .result (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_comb;
    end
  end

  assign m_tdata = {5'd0, res};

endmodule

`default_nettype wire
